// ===== rtl/nearest_neighbor_scale_address_gen_macros.svh =====
// ---------------------------------------------------------------------------
// nearest neighbor scale address generator assertion macros
// concurrent property wrappers clocked on i_clk, disabled during reset
// ---------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_MACROS_SVH

// same-cycle implication
`define NNSAG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NNSAG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nnsag_pkg.sv =====
// ---------------------------------------------------------------------------
// nnsag_pkg
// shared widths, register indexes and state encoding of the scale address
// generator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nnsag_pkg;

    // field widths
    localparam int ADDR_W      = 32;
    localparam int STRIDE_W    = 17;
    localparam int SIZE_W      = 13;
    localparam int OFFSET_W    = 12;
    localparam int COORD_W     = 12;

    // port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = ADDR_W + 2 * COORD_W;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_BASE      = 3'd0,
        CFG_ROW_STRIDE       = 3'd1,
        CFG_SRC_WIDTH        = 3'd2,
        CFG_SRC_HEIGHT       = 3'd3,
        CFG_DST_WIDTH        = 3'd4,
        CFG_DST_HEIGHT       = 3'd5,
        CFG_CONTENT_OFFSET_X = 3'd6,
        CFG_CONTENT_OFFSET_Y = 3'd7
    } t_cfg_index;

    // control sequencer states
    typedef enum logic [1:0] {
        S_RUN,
        S_DIVIDE,
        S_SCALE,
        S_ISSUE
    } t_state;

endpackage

// ===== rtl/nnsag_div.sv =====
// ---------------------------------------------------------------------------
// nnsag_div
// restoring radix-2 divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nnsag_div #(
    parameter int W = 13
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    import nnsag_pkg::*;

    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_div;

    logic [W:0]       shifted;
    logic [W+1:0]     diff;
    logic             ge;
    logic [W-1:0]     n_rem;
    logic [W-1:0]     n_quo;

    // one trial subtraction
    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        ge      = ~diff[W+1];
        n_rem   = ge ? diff[W-1:0] : shifted[W-1:0];
        n_quo   = {r_quo[W-2:0], ge};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/nearest_neighbor_scale_address_gen.sv =====
// ---------------------------------------------------------------------------
// nearest_neighbor_scale_address_gen: raster source address generator
// within a frame one address per cycle unless the result stream stalls, result in the cycle
// after the transfer; a frame start holds s_axis_tready low through divide, scale and issue, its
// result issued from issue; synchronous active-low reset, first transfer starts a frame
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_neighbor_scale_address_gen_macros.svh"

module nearest_neighbor_scale_address_gen #(
    parameter int MAX_DIM         = 4096,
    parameter int BYTES_PER_PIXEL = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [nnsag_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [nnsag_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [nnsag_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] frame_start
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [nnsag_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // source_address, dest_x, dest_y
    output logic                             m_axis_tlast,  // row_end
    output logic                             m_axis_tuser   // frame_end
);

    import nnsag_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int SUM_W  = DIM_W + 1;
    localparam int OFF_W  = $clog2(MAX_DIM * BYTES_PER_PIXEL + 1);
    localparam int PROD_W = OFFSET_W + STRIDE_W;
    localparam int STEP_W = DIM_W + STRIDE_W;

    // configuration registers
    logic [ADDR_W-1:0]   r_cfg_source_base;
    logic [STRIDE_W-1:0] r_cfg_row_stride;
    logic [SIZE_W-1:0]   r_cfg_src_width;
    logic [SIZE_W-1:0]   r_cfg_src_height;
    logic [SIZE_W-1:0]   r_cfg_dst_width;
    logic [SIZE_W-1:0]   r_cfg_dst_height;
    logic [OFFSET_W-1:0] r_cfg_offset_x;
    logic [OFFSET_W-1:0] r_cfg_offset_y;

    // frame state
    t_state              r_state, n_state;
    logic [DIM_W-1:0]    r_frame_dw;
    logic [DIM_W-1:0]    r_frame_dh;
    logic [STRIDE_W-1:0] r_frame_stride;
    logic [CNT_W-1:0]    r_col_count, n_col_count;
    logic [CNT_W-1:0]    r_row_count, n_row_count;
    logic [CNT_W-1:0]    r_col_err, n_col_err;
    logic [CNT_W-1:0]    r_row_err, n_row_err;
    logic [OFF_W-1:0]    r_src_off, n_src_off;
    logic [ADDR_W-1:0]   r_row_address, n_row_address;
    logic [PROD_W-1:0]   r_off_prod;
    logic [STEP_W-1:0]   r_row_step;
    logic [OFF_W-1:0]    r_col_step;

    // result register
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [COORD_W-1:0]  r_out_x;
    logic [COORD_W-1:0]  r_out_y;
    logic                r_out_row_end;
    logic                r_out_frame_end;

    // control
    logic                out_free;
    logic                in_xfer;
    logic                need_setup;
    logic                setup_go;
    logic                issue_step;
    logic                scale_load;
    logic                do_step;
    logic                row_end;
    logic                frame_end;

    // clamped sizes and divider results
    logic [DIM_W-1:0]    clamp_sw, clamp_sh, clamp_dw, clamp_dh;
    logic                col_busy, row_busy;
    logic [DIM_W-1:0]    col_q, col_rem, row_q, row_rem;

    // step arithmetic
    logic [SUM_W-1:0]    col_sum, row_sum;
    logic                col_carry, row_carry;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    assign clamp_sw = clamp_dim(r_cfg_src_width);
    assign clamp_sh = clamp_dim(r_cfg_src_height);
    assign clamp_dw = clamp_dim(r_cfg_dst_width);
    assign clamp_dh = clamp_dim(r_cfg_dst_height);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_source_base <= '0;
            r_cfg_row_stride  <= STRIDE_W'(4);
            r_cfg_src_width   <= SIZE_W'(1);
            r_cfg_src_height  <= SIZE_W'(1);
            r_cfg_dst_width   <= SIZE_W'(1);
            r_cfg_dst_height  <= SIZE_W'(1);
            r_cfg_offset_x    <= '0;
            r_cfg_offset_y    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_BASE:      r_cfg_source_base <= i_cfg_wdata[ADDR_W-1:0];
                CFG_ROW_STRIDE:       r_cfg_row_stride  <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_SRC_WIDTH:        r_cfg_src_width   <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SRC_HEIGHT:       r_cfg_src_height  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_DST_WIDTH:        r_cfg_dst_width   <= i_cfg_wdata[SIZE_W-1:0];
                CFG_DST_HEIGHT:       r_cfg_dst_height  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_CONTENT_OFFSET_X: r_cfg_offset_x    <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_CONTENT_OFFSET_Y: r_cfg_offset_y    <= i_cfg_wdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // per-frame quotient dividers
    nnsag_div #(.W(DIM_W)) u_col_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (setup_go),
        .i_dividend  (clamp_sw),
        .i_divisor   (clamp_dw),
        .o_busy      (col_busy),
        .o_quotient  (col_q),
        .o_remainder (col_rem)
    );

    nnsag_div #(.W(DIM_W)) u_row_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (setup_go),
        .i_dividend  (clamp_sh),
        .i_divisor   (clamp_dh),
        .o_busy      (row_busy),
        .o_quotient  (row_q),
        .o_remainder (row_rem)
    );

    // handshake terms
    assign out_free   = !r_out_valid || m_axis_tready;
    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign need_setup = s_axis_tdata[0] || (r_col_count == '0 && r_row_count == '0);
    assign setup_go   = in_xfer && need_setup;
    assign do_step    = (in_xfer && !need_setup) || issue_step;

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        issue_step    = 1'b0;
        scale_load    = 1'b0;
        case (r_state)
            S_RUN:   s_axis_tready = out_free;
            S_SCALE: scale_load    = 1'b1;
            S_ISSUE: issue_step    = out_free;
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (setup_go) n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (!col_busy && !row_busy) n_state = S_SCALE;
            end
            S_SCALE: n_state = S_ISSUE;
            S_ISSUE: begin
                if (out_free) n_state = S_RUN;
            end
            default: n_state = S_RUN;
        endcase
    end

    // end marks of the current pixel
    assign row_end   = (SUM_W'(r_col_count) + SUM_W'(1)) >= SUM_W'(r_frame_dw);
    assign frame_end = row_end && ((SUM_W'(r_row_count) + SUM_W'(1)) >= SUM_W'(r_frame_dh));

    // dda error accumulators
    assign col_sum   = SUM_W'(r_col_err) + SUM_W'(col_rem);
    assign col_carry = col_sum >= SUM_W'(r_frame_dw);
    assign row_sum   = SUM_W'(r_row_err) + SUM_W'(row_rem);
    assign row_carry = row_sum >= SUM_W'(r_frame_dh);

    // next pixel state
    always_comb begin
        n_col_count   = r_col_count;
        n_row_count   = r_row_count;
        n_col_err     = r_col_err;
        n_row_err     = r_row_err;
        n_src_off     = r_src_off;
        n_row_address = r_row_address;
        if (frame_end) begin
            n_col_count = '0;
            n_row_count = '0;
        end else if (row_end) begin
            n_col_count   = '0;
            n_src_off     = '0;
            n_col_err     = '0;
            n_row_count   = r_row_count + CNT_W'(1);
            n_row_address = r_row_address + ADDR_W'(r_row_step)
                          + (row_carry ? ADDR_W'(r_frame_stride) : '0);
            n_row_err     = CNT_W'(row_carry ? row_sum - SUM_W'(r_frame_dh) : row_sum);
        end else begin
            n_col_count = r_col_count + CNT_W'(1);
            n_src_off   = r_src_off + r_col_step
                        + (col_carry ? OFF_W'(BYTES_PER_PIXEL) : '0);
            n_col_err   = CNT_W'(col_carry ? col_sum - SUM_W'(r_frame_dw) : col_sum);
        end
    end

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_RUN;
            r_out_valid    <= 1'b0;
            r_frame_dw     <= DIM_W'(1);
            r_frame_dh     <= DIM_W'(1);
            r_frame_stride <= STRIDE_W'(4);
            r_col_count    <= '0;
            r_row_count    <= '0;
            r_col_err      <= '0;
            r_row_err      <= '0;
        end else begin
            r_state <= n_state;
            if (do_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (setup_go) begin
                r_frame_dw     <= clamp_dw;
                r_frame_dh     <= clamp_dh;
                r_frame_stride <= r_cfg_row_stride;
                r_col_count    <= '0;
                r_row_count    <= '0;
                r_col_err      <= '0;
                r_row_err      <= '0;
            end else if (do_step) begin
                r_col_count <= n_col_count;
                r_row_count <= n_row_count;
                r_col_err   <= n_col_err;
                r_row_err   <= n_row_err;
            end
        end
    end

    // frame setup products and address datapath
    always_ff @(posedge i_clk) begin
        if (setup_go) begin
            r_off_prod <= PROD_W'(r_cfg_offset_y) * PROD_W'(r_cfg_row_stride);
            r_src_off  <= '0;
        end else if (do_step) begin
            r_src_off  <= n_src_off;
        end
        if (scale_load) begin
            r_row_step    <= STEP_W'(row_q) * STEP_W'(r_frame_stride);
            r_col_step    <= OFF_W'(32'(col_q) * 32'(BYTES_PER_PIXEL));
            r_row_address <= r_cfg_source_base + ADDR_W'(r_off_prod)
                           + ADDR_W'(r_cfg_offset_x) * ADDR_W'(BYTES_PER_PIXEL);
        end else if (do_step) begin
            r_row_address <= n_row_address;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_out_addr      <= r_row_address + ADDR_W'(r_src_off);
            r_out_x         <= COORD_W'(r_col_count);
            r_out_y         <= COORD_W'(r_row_count);
            r_out_row_end   <= row_end;
            r_out_frame_end <= frame_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x, r_out_addr};
    assign m_axis_tlast  = r_out_row_end;
    assign m_axis_tuser  = r_out_frame_end;

    // checks
    `NNSAG_ASSERT_IMP(a_col_in_frame, r_state == S_RUN, SUM_W'(r_col_count) < SUM_W'(r_frame_dw), "column count beyond frame width")
    `NNSAG_ASSERT_IMP(a_row_err_bound, r_state == S_RUN, SUM_W'(r_row_err) < SUM_W'(r_frame_dh), "row error not below frame height")
    `NNSAG_ASSERT_NXT(a_setup_divides, setup_go, r_state == S_DIVIDE, "frame start did not enter divide")
    `NNSAG_ASSERT_IMP(a_frame_end_row_end, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end without row end")

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: nearest neighbor scale address generator testbench
// drives frame-start/advance transfers through the input stream, predicts each
// source address with a cycle-free DDA model kept in step with accepted
// transfers, and checks every result transfer field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import nnsag_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int PIXEL_BYTES = 4;
    localparam int STALL_LIMIT = 3000;
    localparam int TARGET_ITEMS = 1150;

    // one expected output pixel
    typedef struct packed {
        logic [ADDR_W-1:0]  source_address;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic               row_end;
        logic               frame_end;
    } t_pixel_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] frame_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // source_address, dest_x, dest_y
    logic                   m_axis_tlast;        // row_end
    logic                   m_axis_tuser;        // frame_end

    // pending input transfers and expected pixels
    logic          frame_start_q[$];
    t_pixel_result expected_pixels[$];
    t_pixel_result rx_expect;
    int            fail_count = 0;

    // register shadow
    logic [ADDR_W-1:0]   cfg_base = '0;
    logic [STRIDE_W-1:0] cfg_stride = 17'd4;
    logic [SIZE_W-1:0]   cfg_src_w = 13'd1;
    logic [SIZE_W-1:0]   cfg_src_h = 13'd1;
    logic [SIZE_W-1:0]   cfg_dst_w = 13'd1;
    logic [SIZE_W-1:0]   cfg_dst_h = 13'd1;
    logic [OFFSET_W-1:0] cfg_off_x = '0;
    logic [OFFSET_W-1:0] cfg_off_y = '0;

    // scaler state, next pixel to issue and per-frame latched values
    logic [SIZE_W-1:0]   nx_col = '0;
    logic [SIZE_W-1:0]   nx_row = '0;
    logic [SIZE_W-1:0]   src_col = '0;
    logic [SIZE_W-1:0]   col_err = '0;
    logic [SIZE_W-1:0]   row_err = '0;
    logic [ADDR_W-1:0]   row_addr = '0;
    logic [SIZE_W-1:0]   col_quo = '0;
    logic [SIZE_W-1:0]   col_rem = '0;
    logic [SIZE_W-1:0]   row_quo = '0;
    logic [SIZE_W-1:0]   row_rem = '0;
    logic [SIZE_W-1:0]   fr_dw = 13'd1;
    logic [SIZE_W-1:0]   fr_dh = 13'd1;
    logic [STRIDE_W-1:0] fr_stride = 17'd4;

    // handshake pacing
    int   tx_gap = 0;
    int   rx_hold = 0;
    int   idle_cycles = 0;
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;
    logic pressure_done = 1'b0;

    nearest_neighbor_scale_address_gen #(
        .MAX_DIM         (MAX_DIM),
        .BYTES_PER_PIXEL (PIXEL_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // size registers: zero acts as one, oversize acts as the maximum
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        if (v == '0) return 13'd1;
        if (int'(v) > MAX_DIM) return SIZE_W'(MAX_DIM);
        return v;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap(input logic calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // mostly small frames, now and then an extreme size
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(1, 8);
        if (roll < 88) return $urandom_range(9, 40);
        case ($urandom_range(5))
            0: return 0;
            1: return 4095;
            2: return 4096;
            3: return 4097;
            4: return 8191;
            default: return $urandom_range(8191);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_stride();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return $urandom_range(4, 64);
        if (roll < 80) return $urandom_range(4, 65536);
        if (roll < 90) return 65536;
        return $urandom_range(0, 131071);
    endfunction

    // advance the scaler by one pixel and queue the pixel it issues
    task automatic predict_source_pixel(input logic restart);
        t_pixel_result px;
        logic          row_last;
        logic          frame_last;
        logic [SIZE_W-1:0] sw;
        logic [SIZE_W-1:0] sh;
        // latch the frame geometry and find the step quotients
        if (restart || (nx_col == '0 && nx_row == '0)) begin
            sw = clamp_size(cfg_src_w);
            sh = clamp_size(cfg_src_h);
            fr_dw = clamp_size(cfg_dst_w);
            fr_dh = clamp_size(cfg_dst_h);
            fr_stride = cfg_stride;
            col_quo = sw / fr_dw;
            col_rem = sw % fr_dw;
            row_quo = sh / fr_dh;
            row_rem = sh % fr_dh;
            nx_col = '0;
            nx_row = '0;
            src_col = '0;
            col_err = '0;
            row_err = '0;
            row_addr = cfg_base + 32'(cfg_off_y) * 32'(fr_stride)
                     + 32'(cfg_off_x) * 32'(PIXEL_BYTES);
        end
        row_last = (int'(nx_col) + 1 >= int'(fr_dw));
        frame_last = row_last && (int'(nx_row) + 1 >= int'(fr_dh));
        px.source_address = row_addr + 32'(src_col) * 32'(PIXEL_BYTES);
        px.dest_x = nx_col[COORD_W-1:0];
        px.dest_y = nx_row[COORD_W-1:0];
        px.row_end = row_last;
        px.frame_end = frame_last;
        expected_pixels.push_back(px);
        // step the column or row accumulators
        if (frame_last) begin
            nx_col = '0;
            nx_row = '0;
        end else if (row_last) begin
            nx_col = '0;
            src_col = '0;
            col_err = '0;
            nx_row = nx_row + 13'd1;
            row_addr = row_addr + 32'(row_quo) * 32'(fr_stride);
            row_err = row_err + row_rem;
            if (row_err >= fr_dh) begin
                row_err = row_err - fr_dh;
                row_addr = row_addr + 32'(fr_stride);
            end
        end else begin
            nx_col = nx_col + 13'd1;
            src_col = src_col + col_quo;
            col_err = col_err + col_rem;
            if (col_err >= fr_dw) begin
                col_err = col_err - fr_dw;
                src_col = src_col + 13'd1;
            end
        end
    endtask

    // one register write, shadow updated alongside
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SOURCE_BASE:      cfg_base = val;
            CFG_ROW_STRIDE:       cfg_stride = val[STRIDE_W-1:0];
            CFG_SRC_WIDTH:        cfg_src_w = val[SIZE_W-1:0];
            CFG_SRC_HEIGHT:       cfg_src_h = val[SIZE_W-1:0];
            CFG_DST_WIDTH:        cfg_dst_w = val[SIZE_W-1:0];
            CFG_DST_HEIGHT:       cfg_dst_h = val[SIZE_W-1:0];
            CFG_CONTENT_OFFSET_X: cfg_off_x = val[OFFSET_W-1:0];
            CFG_CONTENT_OFFSET_Y: cfg_off_y = val[OFFSET_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // all pending transfers accepted and every expected pixel seen
    task automatic wait_idle();
        do @(negedge i_clk);
        while (frame_start_q.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_frame_starts(input int count, input int restart_pct);
        for (int k = 0; k < count; k++)
            frame_start_q.push_back($urandom_range(99) < restart_pct);
    endtask

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // input stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            tx_gap <= 0;
        end else begin
            if ($urandom_range(199) == 0) tx_calm <= ~tx_calm;
            if (s_axis_tvalid && s_axis_tready) predict_source_pixel(s_axis_tdata[0]);
            // load the next transfer once the current one is gone
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (frame_start_q.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, frame_start_q.pop_front()};
                    tx_gap <= pick_gap(tx_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result stream monitor and backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold <= 0;
        end else begin
            if ($urandom_range(199) == 0) rx_calm <= ~rx_calm;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result transfer with no pixel expected: tdata %h", m_axis_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    rx_expect = expected_pixels.pop_front();
                    if (m_axis_tdata[31:0] !== rx_expect.source_address) begin
                        $error("source_address expected %h actual %h",
                               rx_expect.source_address, m_axis_tdata[31:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[43:32] !== rx_expect.dest_x) begin
                        $error("dest_x expected %0d actual %0d",
                               rx_expect.dest_x, m_axis_tdata[43:32]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[55:44] !== rx_expect.dest_y) begin
                        $error("dest_y expected %0d actual %0d",
                               rx_expect.dest_y, m_axis_tdata[55:44]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tlast !== rx_expect.row_end) begin
                        $error("row_end expected %b actual %b", rx_expect.row_end, m_axis_tlast);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tuser !== rx_expect.frame_end) begin
                        $error("frame_end expected %b actual %b",
                               rx_expect.frame_end, m_axis_tuser);
                        fail_count = fail_count + 1;
                    end
                end
            end
            // one long hold-off while the sender still has plenty queued
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (!pressure_done && frame_start_q.size() > 40) begin
                pressure_done <= 1'b1;
                rx_hold <= 400;
                m_axis_tready <= 1'b0;
            end else begin
                int g;
                g = pick_gap(rx_calm);
                if (g == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    rx_hold <= g - 1;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        int sent;
        int phase;
        int count;
        int restart_pct;
        sent = 0;
        phase = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: every pixel is a whole 1x1 frame, wraps on its own
        frame_start_q.push_back(1'b0);
        frame_start_q.push_back(1'b0);
        frame_start_q.push_back(1'b1);
        frame_start_q.push_back(1'b0);
        wait_idle();

        // extreme base, stride and offsets, zero and oversize source sizes
        write_reg(CFG_SOURCE_BASE, 32'hFFFF_FFF0);
        write_reg(CFG_ROW_STRIDE, 32'h0001_FFFF);
        write_reg(CFG_SRC_WIDTH, 32'd0);
        write_reg(CFG_SRC_HEIGHT, 32'd8191);
        write_reg(CFG_DST_WIDTH, 32'd3);
        write_reg(CFG_DST_HEIGHT, 32'd2);
        write_reg(CFG_CONTENT_OFFSET_X, 32'd4095);
        write_reg(CFG_CONTENT_OFFSET_Y, 32'd4095);
        queue_frame_starts(6, 0);
        wait_idle();

        // size change in the middle of a frame applies only at the next one
        write_reg(CFG_SRC_WIDTH, 32'd8);
        write_reg(CFG_SRC_HEIGHT, 32'd1);
        write_reg(CFG_DST_WIDTH, 32'd4);
        queue_frame_starts(3, 0);
        wait_idle();
        write_reg(CFG_SRC_WIDTH, 32'd3);
        write_reg(CFG_DST_WIDTH, 32'd5);
        write_reg(CFG_ROW_STRIDE, 32'd4);
        queue_frame_starts(7, 0);
        wait_idle();

        // widest destination row, zero height, restarts mid-row
        write_reg(CFG_SRC_WIDTH, 32'd4096);
        write_reg(CFG_DST_WIDTH, 32'd8191);
        write_reg(CFG_DST_HEIGHT, 32'd0);
        frame_start_q.push_back(1'b1);
        frame_start_q.push_back(1'b0);
        frame_start_q.push_back(1'b0);
        frame_start_q.push_back(1'b1);
        frame_start_q.push_back(1'b0);
        wait_idle();

        // random geometry, mostly whole frames with occasional restarts
        while (sent < TARGET_ITEMS) begin
            if (phase == 0 || $urandom_range(1)) write_reg(CFG_SOURCE_BASE, $urandom());
            if (phase == 0 || $urandom_range(1)) write_reg(CFG_ROW_STRIDE, pick_stride());
            if (phase == 0 || $urandom_range(1)) write_reg(CFG_SRC_WIDTH, pick_size());
            if (phase == 0 || $urandom_range(1)) write_reg(CFG_SRC_HEIGHT, pick_size());
            write_reg(CFG_DST_WIDTH, pick_size());
            write_reg(CFG_DST_HEIGHT, pick_size());
            if (phase == 0 || $urandom_range(1))
                write_reg(CFG_CONTENT_OFFSET_X, $urandom_range(4095));
            if (phase == 0 || $urandom_range(1))
                write_reg(CFG_CONTENT_OFFSET_Y, $urandom_range(4095));
            count = (phase == 0) ? 200 : $urandom_range(30, 150);
            // last batch stops at the item target
            if (count > TARGET_ITEMS - sent) count = TARGET_ITEMS - sent;
            restart_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(3) == 0) begin
                frame_start_q.push_back(1'b1);
                count = count - 1;
                sent = sent + 1;
            end
            queue_frame_starts(count, restart_pct);
            sent = sent + count;
            phase = phase + 1;
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
